// ===== hdl/zb_pkg.sv =====
// ----------------------------------------------------------------------------
// zb_pkg
// Shared types and constants of the point projection z-buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package zb_pkg;

   // operation codes of an input item
   localparam logic [1:0] OP_PROJECT    = 2'd0;
   localparam logic [1:0] OP_READ       = 2'd1;
   localparam logic [1:0] OP_READ_CLEAR = 2'd2;

   // configuration register indexes
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_RANGE  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_RANGE  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FOCAL_COL  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FOCAL_ROW  = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_COL = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_ROW = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_COLS_USED  = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_ROWS_USED  = 4'd7;
   localparam int CSR_DATA_W = 23;

   // reset values of the registers
   localparam logic [22:0] MIN_RANGE_RST  = 23'd0;
   localparam logic [22:0] MAX_RANGE_RST  = 23'd100000;
   localparam logic [19:0] FOCAL_RST      = 20'd8192;
   localparam logic [9:0]  CENTER_COL_RST = 10'd512;
   localparam logic [6:0]  CENTER_ROW_RST = 7'd64;
   localparam logic [10:0] COLS_USED_RST  = 11'd1024;
   localparam logic [7:0]  ROWS_USED_RST  = 8'd128;

   localparam logic [7:0] SAT_WRITTEN = 8'd254;
   localparam logic [7:0] BYTE_MAX    = 8'd255;
   localparam logic [9:0] BRIGHT_GAIN = 10'd961;   // (2 * 15.5) squared

   // divider geometry: numerator 2*|c|*f + 16*z, denominator 32*z
   localparam int MAG_W      = 43;
   localparam int DIV_NUM_W  = 45;
   localparam int DIV_DEN_W  = 28;

   typedef struct packed {
      logic [22:0] near_limit;
      logic [22:0] far_limit;
      logic [19:0] focal_col;
      logic [19:0] focal_row;
      logic [9:0]  center_col;
      logic [6:0]  center_row;
      logic [10:0] cols_used;
      logic [7:0]  rows_used;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic [15:0]        strength;
      logic [19:0]        point_number;
      logic [9:0]         read_col;
      logic [6:0]         read_row;
   } req_type;

   typedef struct packed {
      logic        in_view;
      logic        stored;
      logic [9:0]  pix_col;
      logic [6:0]  pix_row;
      logic        occupied;
      logic [7:0]  hue;
      logic [7:0]  saturation;
      logic [7:0]  brightness;
      logic [19:0] owner_index;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_ZERO,
      KIND_PROJ,
      KIND_READ,
      KIND_CLEAR
   } kind_type;

   // classified item between front and back
   typedef struct packed {
      kind_type         kind;
      logic             neg_x;
      logic [MAG_W-1:0] mag_x;
      logic             neg_y;
      logic [MAG_W-1:0] mag_y;
      logic [22:0]      depth;
      logic [15:0]      strength;
      logic [19:0]      point_number;
      logic [9:0]       read_col;
      logic [6:0]       read_row;
   } item_type;

endpackage

`default_nettype wire

// ===== hdl/zb_div.sv =====
// ----------------------------------------------------------------------------
// zb_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module zb_div import zb_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_NUM_W-1:0] num,
   input  wire logic [DIV_DEN_W-1:0] den,
   output logic                      done,
   output logic [DIV_NUM_W-1:0]      quo
);

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_NUM_W-1:0] sh_ff;

   logic [DIV_DEN_W:0]   trial;
   logic                 ge;
   logic [DIV_DEN_W:0]   rem_in;

   always_comb begin
      trial  = {rem_ff, sh_ff[DIV_NUM_W-1]};
      ge     = trial >= {1'b0, den_ff};
      rem_in = ge ? (trial - {1'b0, den_ff}) : trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_NUM_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   // quotient bits shift in where numerator bits leave
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= den;
         sh_ff  <= num;
      end else if (busy_ff) begin
         rem_ff <= rem_in[DIV_DEN_W-1:0];
         sh_ff  <= {sh_ff[DIV_NUM_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quo  = sh_ff;

endmodule

`default_nettype wire

// ===== hdl/zb_queue.sv =====
// ----------------------------------------------------------------------------
// zb_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module zb_queue import zb_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type wdata,
   output logic          full,
   input  wire logic     pop,
   output item_type      rdata,
   output logic          empty
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign full    = count_ff == 2'd2;
   assign empty   = count_ff == 2'd0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         if (do_push && !do_pop)      count_ff <= count_ff + 2'd1;
         else if (do_pop && !do_push) count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= wdata;
   end

endmodule

`default_nettype wire

// ===== hdl/zb_front.sv =====
// ----------------------------------------------------------------------------
// zb_front
// Classifies an incoming item: depth gate, op decode and the focal products.
// ----------------------------------------------------------------------------
`default_nettype none

module zb_front import zb_pkg::*; (
   input  wire req_type cfg_req,
   input  wire cfg_type cfg,
   output item_type     item
);

   logic [22:0] lo;
   logic        z_ok;
   logic [23:0] abs_x;
   logic [23:0] abs_y;

   always_comb begin
      lo    = (cfg.near_limit == '0) ? 23'd1 : cfg.near_limit;
      z_ok  = !cfg_req.pos_z[23] && (cfg_req.pos_z[22:0] >= lo)
              && (cfg_req.pos_z[22:0] <= cfg.far_limit);
      abs_x = cfg_req.pos_x[23] ? (24'd0 - cfg_req.pos_x) : cfg_req.pos_x;
      abs_y = cfg_req.pos_y[23] ? (24'd0 - cfg_req.pos_y) : cfg_req.pos_y;

      item.neg_x        = cfg_req.pos_x[23];
      item.neg_y        = cfg_req.pos_y[23];
      item.mag_x        = {19'd0, abs_x} * {23'd0, cfg.focal_col};
      item.mag_y        = {19'd0, abs_y} * {23'd0, cfg.focal_row};
      item.depth        = cfg_req.pos_z[22:0];
      item.strength     = cfg_req.strength;
      item.point_number = cfg_req.point_number;
      item.read_col     = cfg_req.read_col;
      item.read_row     = cfg_req.read_row;

      unique case (cfg_req.op)
         OP_PROJECT:    item.kind = z_ok ? KIND_PROJ : KIND_ZERO;
         OP_READ:       item.kind = KIND_READ;
         OP_READ_CLEAR: item.kind = KIND_CLEAR;
         default:       item.kind = KIND_ZERO;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/zb_back.sv =====
// ----------------------------------------------------------------------------
// zb_back
// Executes items: divisions, bounds check, pixel store access, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module zb_back import zb_pkg::*; #(
   parameter int MAX_COLS   = 1024,
   parameter int MAX_ROWS   = 128,
   parameter int INDEX_BITS = 20
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     q_empty,
   input  wire item_type q_data,
   output logic          q_pop,
   input  wire logic     rsp_pop,
   output logic          rsp_empty,
   output rsp_type       rsp_data,
   output logic          clearing
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OWN_W  = (INDEX_BITS < 20) ? INDEX_BITS : 20;
   localparam int ENT_W  = 17 + OWN_W;
   localparam logic [12:0] COLS_LIM = 13'(MAX_COLS);
   localparam logic [12:0] ROWS_LIM = 13'(MAX_ROWS);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DCOL, S_DROW, S_DHUE, S_CHK, S_MRD, S_PWR, S_RRD, S_ZERO
   } state_type;

   logic [ENT_W-1:0] mem [DEPTH];

   state_type            state_ff;
   item_type             item_ff;
   logic [ADDR_W-1:0]    clr_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [ENT_W-1:0]     rd_ff;
   logic [DIV_NUM_W-1:0] qcol_ff;
   logic [DIV_NUM_W-1:0] qrow_ff;
   logic [7:0]           hue_ff;
   logic [10:0]          col_ff;
   logic [7:0]           row_ff;
   logic                 oob_ff;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;
   logic [26:0]          sq_rem_ff;
   logic [26:0]          sq_root_ff;
   logic [26:0]          sq_bit_ff;

   logic                 slot_free;
   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quo;
   logic [26:0]          sq_sum;
   logic [12:0]          wlim;
   logic [12:0]          hlim;
   logic [DIV_NUM_W:0]   col_sum;
   logic [DIV_NUM_W:0]   row_sum;
   logic [9:0]           col_diff;
   logic [6:0]           row_diff;
   logic                 col_ok;
   logic                 row_ok;
   logic [10:0]          colc;
   logic [7:0]           rowc;
   logic [7:0]           bright;
   logic                 win;
   logic                 read_oob;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [ENT_W-1:0]     wr_data;
   logic                 rsp_load;
   rsp_type              rsp_in;

   zb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign slot_free = !rsp_valid_ff || rsp_pop;
   assign q_pop     = (state_ff == S_IDLE) && !q_empty;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign clearing  = state_ff == S_CLEAR;

   // divider operands: column, then row, then hue
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      if (q_pop && q_data.kind == KIND_PROJ) begin
         div_start = 1'b1;
         div_num   = DIV_NUM_W'({q_data.mag_x, 1'b0}) + DIV_NUM_W'({q_data.depth, 4'b0});
         div_den   = {q_data.depth, 5'b0};
      end else if (state_ff == S_DCOL && div_done) begin
         div_start = 1'b1;
         div_num   = DIV_NUM_W'({item_ff.mag_y, 1'b0}) + DIV_NUM_W'({item_ff.depth, 4'b0});
         div_den   = {item_ff.depth, 5'b0};
      end else if (state_ff == S_DROW && div_done) begin
         div_start = 1'b1;
         div_num   = DIV_NUM_W'({item_ff.depth, 8'b0}) - DIV_NUM_W'(item_ff.depth);
         div_den   = DIV_DEN_W'(cfg.far_limit);
      end
   end

   // signed projection plus center, checked against the used image area
   always_comb begin
      wlim = (13'(cfg.cols_used) < COLS_LIM) ? 13'(cfg.cols_used) : COLS_LIM;
      hlim = (13'(cfg.rows_used) < ROWS_LIM) ? 13'(cfg.rows_used) : ROWS_LIM;
      col_sum  = (DIV_NUM_W+1)'(qcol_ff) + (DIV_NUM_W+1)'(cfg.center_col);
      row_sum  = (DIV_NUM_W+1)'(qrow_ff) + (DIV_NUM_W+1)'(cfg.center_row);
      col_diff = cfg.center_col - qcol_ff[9:0];
      row_diff = cfg.center_row - qrow_ff[6:0];
      if (item_ff.neg_x) begin
         col_ok = (qcol_ff <= DIV_NUM_W'(cfg.center_col)) && (13'(col_diff) < wlim);
         colc   = 11'(col_diff);
      end else begin
         col_ok = col_sum < (DIV_NUM_W+1)'(wlim);
         colc   = col_sum[10:0];
      end
      if (item_ff.neg_y) begin
         row_ok = (qrow_ff <= DIV_NUM_W'(cfg.center_row)) && (13'(row_diff) < hlim);
         rowc   = 8'(row_diff);
      end else begin
         row_ok = row_sum < (DIV_NUM_W+1)'(hlim);
         rowc   = row_sum[7:0];
      end
      sq_sum = sq_root_ff + sq_bit_ff;
      bright = (sq_root_ff[26:1] > 26'(BYTE_MAX)) ? BYTE_MAX : sq_root_ff[8:1];
      win    = !rd_ff[0] || (rd_ff[8:1] > hue_ff);
      read_oob = (int'(q_data.read_col) >= MAX_COLS) || (int'(q_data.read_row) >= MAX_ROWS);
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
         end
         S_PWR: begin
            wr_en   = slot_free && win;
            wr_data = {item_ff.point_number[OWN_W-1:0], bright, hue_ff, 1'b1};
         end
         S_RRD: begin
            wr_en = slot_free && item_ff.kind == KIND_CLEAR && !oob_ff;
         end
         default: begin
         end
      endcase
   end

   // result built for the state that hands it over
   always_comb begin
      rsp_load = 1'b0;
      rsp_in   = '0;
      unique case (state_ff)
         S_PWR: begin
            rsp_load       = slot_free;
            rsp_in.in_view = 1'b1;
            rsp_in.stored  = win;
            rsp_in.pix_col = col_ff[9:0];
            rsp_in.pix_row = row_ff[6:0];
         end
         S_RRD: begin
            rsp_load       = slot_free;
            rsp_in.pix_col = item_ff.read_col;
            rsp_in.pix_row = item_ff.read_row;
            if (!oob_ff && rd_ff[0]) begin
               rsp_in.occupied    = 1'b1;
               rsp_in.hue         = rd_ff[8:1];
               rsp_in.saturation  = SAT_WRITTEN;
               rsp_in.brightness  = rd_ff[16:9];
               rsp_in.owner_index = 20'(rd_ff[ENT_W-1:17]);
            end
         end
         S_ZERO: begin
            rsp_load = slot_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (rsp_load) rsp_ff <= rsp_in;
   end

   // brightness root runs beside the divisions
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_bit_ff <= '0;
      end else if (q_pop && q_data.kind == KIND_PROJ) begin
         sq_rem_ff  <= {11'd0, q_data.strength} * {17'd0, BRIGHT_GAIN};
         sq_root_ff <= '0;
         sq_bit_ff  <= 27'd1 << 24;
      end else if (sq_bit_ff != '0) begin
         if (sq_rem_ff >= sq_sum) begin
            sq_rem_ff  <= sq_rem_ff - sq_sum;
            sq_root_ff <= (sq_root_ff >> 1) + sq_bit_ff;
         end else begin
            sq_root_ff <= sq_root_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_pop);
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == ADDR_W'(DEPTH - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (!q_empty) begin
                  item_ff <= q_data;
                  oob_ff  <= read_oob;
                  addr_ff <= read_oob ? '0 :
                     ADDR_W'(int'(q_data.read_row) * MAX_COLS + int'(q_data.read_col));
                  unique case (q_data.kind)
                     KIND_PROJ:  state_ff <= S_DCOL;
                     KIND_READ,
                     KIND_CLEAR: state_ff <= S_MRD;
                     default:    state_ff <= S_ZERO;
                  endcase
               end
            end
            S_DCOL: begin
               if (div_done) begin
                  qcol_ff  <= div_quo;
                  state_ff <= S_DROW;
               end
            end
            S_DROW: begin
               if (div_done) begin
                  qrow_ff  <= div_quo;
                  state_ff <= S_DHUE;
               end
            end
            S_DHUE: begin
               if (div_done) begin
                  hue_ff   <= div_quo[7:0];
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               if (sq_bit_ff == '0) begin
                  col_ff  <= colc;
                  row_ff  <= rowc;
                  addr_ff <= ADDR_W'(int'(rowc) * MAX_COLS + int'(colc));
                  state_ff <= (col_ok && row_ok) ? S_MRD : S_ZERO;
               end
            end
            S_MRD: begin
               state_ff <= (item_ff.kind == KIND_PROJ) ? S_PWR : S_RRD;
            end
            S_PWR,
            S_RRD,
            S_ZERO: begin
               if (slot_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hdl/point_projection_zbuffer.sv =====
// ----------------------------------------------------------------------------
// point_projection_zbuffer
// Pinhole projection of points into a depth-tested pixel store, with reads.
// ----------------------------------------------------------------------------
// After reset the pixel store is swept clear, one entry per cycle, over all
// MAX_ROWS*MAX_COLS entries (131072 at the defaults); req_full stays high during
// that pass, while register writes are taken at any time. For a project item
// the shared one-bit-per-cycle divider runs three 45-step divisions in turn
// (column, row, hue), followed by the bounds check and, for a pixel in view, a
// store read and a write when the depth test wins. A read or read-and-clear
// reads the store and hands over its result. Items are handled one at a time.
// A two-entry queue in front and a result register behind let both sides stall
// independently.
`default_nettype none

module point_projection_zbuffer import zb_pkg::*; #(
   parameter int MAX_COLS   = 1024,
   parameter int MAX_ROWS   = 128,
   parameter int INDEX_BITS = 20
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire req_type                req_data,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type  cfg_ff;
   item_type front_item;
   item_type q_data;
   logic     q_full;
   logic     q_empty;
   logic     q_pop;
   logic     clearing;

   assign csr_ready = 1'b1;
   assign req_full  = q_full || clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_limit <= MIN_RANGE_RST;
         cfg_ff.far_limit  <= MAX_RANGE_RST;
         cfg_ff.focal_col  <= FOCAL_RST;
         cfg_ff.focal_row  <= FOCAL_RST;
         cfg_ff.center_col <= CENTER_COL_RST;
         cfg_ff.center_row <= CENTER_ROW_RST;
         cfg_ff.cols_used  <= COLS_USED_RST;
         cfg_ff.rows_used  <= ROWS_USED_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MIN_RANGE:  cfg_ff.near_limit <= csr_data;
            REG_MAX_RANGE:  cfg_ff.far_limit  <= csr_data;
            REG_FOCAL_COL:  cfg_ff.focal_col  <= csr_data[19:0];
            REG_FOCAL_ROW:  cfg_ff.focal_row  <= csr_data[19:0];
            REG_CENTER_COL: cfg_ff.center_col <= csr_data[9:0];
            REG_CENTER_ROW: cfg_ff.center_row <= csr_data[6:0];
            REG_COLS_USED:  cfg_ff.cols_used  <= csr_data[10:0];
            REG_ROWS_USED:  cfg_ff.rows_used  <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   zb_front u_front (
      .cfg_req (req_data),
      .cfg     (cfg_ff),
      .item    (front_item)
   );

   zb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push && !req_full),
      .wdata (front_item),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_data),
      .empty (q_empty)
   );

   zb_back #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .clearing  (clearing)
   );

endmodule

`default_nettype wire

// ===== hdl/zb_checker.sv =====
// ----------------------------------------------------------------------------
// zb_checker
// Port-level checks of the point projection z-buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module zb_checker import zb_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_full,
   input wire logic    rsp_empty,
   input wire logic    rsp_pop,
   input wire rsp_type rsp_data
);

   // store sweep blocks input right after reset
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_full)
      else $error("input open during clear pass");

   a_stored_in_view: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.stored) |-> rsp_data.in_view)
      else $error("stored without in_view");

   a_occupied_read: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.occupied) |->
         (rsp_data.saturation == SAT_WRITTEN && !rsp_data.in_view && !rsp_data.stored))
      else $error("occupied result malformed");

   a_empty_pixel: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.occupied) |->
         (rsp_data.hue == '0 && rsp_data.saturation == '0
          && rsp_data.brightness == '0 && rsp_data.owner_index == '0))
      else $error("empty pixel carries data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed");

endmodule

bind point_projection_zbuffer zb_checker u_zb_checker (.*);

`default_nettype wire

// ===== dv/tb_point_projection_zbuffer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_projection_zbuffer
// Self-checking bench for the point projection z-buffer: a clocked driver
// feeds points and pixel reads from a queue, a clocked monitor checks each
// response against an in-bench model of the projection, the depth test and
// the pixel store, across several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_point_projection_zbuffer;
   import zb_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int NUM_COLS = 1024;
   localparam int NUM_ROWS = 128;
   localparam int DRAIN_CYCLES = 400;
   localparam int REQ_W = $bits(req_type);

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_push = 1'b0;
   logic          req_full;
   req_type       req_data = '0;
   logic          rsp_empty;
   logic          rsp_pop = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   point_projection_zbuffer dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("TEST FAILED");
      $finish;
   end

   // model state
   cfg_type        cfg;
   bit [36:0]      pixel_mem [int];
   int             hit_addrs[$];
   req_type        pending_items[$];
   rsp_type        expected_rsps[$];
   int             error_count = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             hold_left = 0;

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bit_val;
      root = 0;
      bit_val = 64'd1 << 40;
      while (bit_val > n) bit_val >>= 2;
      while (bit_val != 0) begin
         if (n >= root + bit_val) begin
            n -= root + bit_val;
            root = (root >> 1) + bit_val;
         end else begin
            root >>= 1;
         end
         bit_val >>= 2;
      end
      return root;
   endfunction

   // round half away from zero of focal*coord/(16*z)
   function automatic longint project_axis(longint unsigned focal, longint coord,
                                           longint z);
      longint unsigned mag, den, q;
      mag = (coord < 0 ? -coord : coord) * focal;
      den = z * 16;
      q = (2 * mag + den) / (2 * den);
      return coord < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic rsp_type predict_pixel(req_type r);
      rsp_type res;
      longint x, y, z, lo, colc, rowc, wlim, hlim;
      longint unsigned hue, bright;
      int addr;
      bit [36:0] entry;
      res = '0;
      case (r.op)
         OP_PROJECT: begin
            x = r.pos_x;
            y = r.pos_y;
            z = r.pos_z;
            lo = cfg.near_limit < 1 ? 1 : cfg.near_limit;
            if (z < lo || z > longint'(cfg.far_limit)) return res;
            colc = project_axis(cfg.focal_col, x, z) + cfg.center_col;
            rowc = project_axis(cfg.focal_row, y, z) + cfg.center_row;
            wlim = cfg.cols_used < NUM_COLS ? cfg.cols_used : NUM_COLS;
            hlim = cfg.rows_used < NUM_ROWS ? cfg.rows_used : NUM_ROWS;
            if (colc < 0 || rowc < 0 || colc >= wlim || rowc >= hlim) return res;
            res.in_view = 1'b1;
            res.pix_col = colc[9:0];
            res.pix_row = rowc[6:0];
            addr = int'(rowc) * NUM_COLS + int'(colc);
            entry = pixel_mem.exists(addr) ? pixel_mem[addr] : '0;
            hue = (longint'(z) * 255) / cfg.far_limit;
            if (!entry[0] || entry[8:1] > hue) begin
               bright = int_sqrt(961 * longint'(r.strength)) >> 1;
               if (bright > 255) bright = 255;
               pixel_mem[addr] = {r.point_number, bright[7:0], hue[7:0], 1'b1};
               res.stored = 1'b1;
               if (hit_addrs.size() < 64) hit_addrs.push_back(addr);
               else hit_addrs[$urandom_range(63)] = addr;
            end
         end
         OP_READ, OP_READ_CLEAR: begin
            res.pix_col = r.read_col;
            res.pix_row = r.read_row;
            addr = int'(r.read_row) * NUM_COLS + int'(r.read_col);
            entry = pixel_mem.exists(addr) ? pixel_mem[addr] : '0;
            if (entry[0]) begin
               res.occupied = 1'b1;
               res.hue = entry[8:1];
               res.saturation = SAT_WRITTEN;
               res.brightness = entry[16:9];
               res.owner_index = entry[36:17];
            end
            if (r.op == OP_READ_CLEAR && pixel_mem.exists(addr)) pixel_mem.delete(addr);
         end
         default: ;
      endcase
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (req_push && !req_full) begin
         expected_rsps.push_back(predict_pixel(req_data));
         void'(pending_items.pop_front());
      end
   end

   always @(negedge clock) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
         req_push <= 1'b1;
         req_data <= pending_items[0];
      end else begin
         req_push <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (rsp_pop && !rsp_empty) begin
         if (expected_rsps.size() == 0) begin
            $error("response transfer with nothing expected");
            error_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data.in_view !== exp_rsp.in_view) begin
               $error("in_view exp %0d got %0d", exp_rsp.in_view, rsp_data.in_view);
               error_count++;
            end
            if (rsp_data.stored !== exp_rsp.stored) begin
               $error("stored exp %0d got %0d", exp_rsp.stored, rsp_data.stored);
               error_count++;
            end
            if (rsp_data.pix_col !== exp_rsp.pix_col) begin
               $error("pix_col exp %0d got %0d", exp_rsp.pix_col, rsp_data.pix_col);
               error_count++;
            end
            if (rsp_data.pix_row !== exp_rsp.pix_row) begin
               $error("pix_row exp %0d got %0d", exp_rsp.pix_row, rsp_data.pix_row);
               error_count++;
            end
            if (rsp_data.occupied !== exp_rsp.occupied) begin
               $error("occupied exp %0d got %0d", exp_rsp.occupied, rsp_data.occupied);
               error_count++;
            end
            if (rsp_data.hue !== exp_rsp.hue) begin
               $error("hue exp %0d got %0d", exp_rsp.hue, rsp_data.hue);
               error_count++;
            end
            if (rsp_data.saturation !== exp_rsp.saturation) begin
               $error("saturation exp %0d got %0d", exp_rsp.saturation,
                      rsp_data.saturation);
               error_count++;
            end
            if (rsp_data.brightness !== exp_rsp.brightness) begin
               $error("brightness exp %0d got %0d", exp_rsp.brightness,
                      rsp_data.brightness);
               error_count++;
            end
            if (rsp_data.owner_index !== exp_rsp.owner_index) begin
               $error("owner_index exp %0d got %0d", exp_rsp.owner_index,
                      rsp_data.owner_index);
               error_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
      rsp_pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, int unsigned val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_MIN_RANGE:  cfg.near_limit = val[22:0];
         REG_MAX_RANGE:  cfg.far_limit = val[22:0];
         REG_FOCAL_COL:  cfg.focal_col = val[19:0];
         REG_FOCAL_ROW:  cfg.focal_row = val[19:0];
         REG_CENTER_COL: cfg.center_col = val[9:0];
         REG_CENTER_ROW: cfg.center_row = val[6:0];
         REG_COLS_USED:  cfg.cols_used = val[10:0];
         REG_ROWS_USED:  cfg.rows_used = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(int unsigned min_r, int unsigned max_r, int unsigned fc,
                             int unsigned fr, int unsigned cc, int unsigned cr,
                             int unsigned cu, int unsigned ru);
      write_reg(REG_MIN_RANGE, min_r);
      write_reg(REG_MAX_RANGE, max_r);
      write_reg(REG_FOCAL_COL, fc);
      write_reg(REG_FOCAL_ROW, fr);
      write_reg(REG_CENTER_COL, cc);
      write_reg(REG_CENTER_ROW, cr);
      write_reg(REG_COLS_USED, cu);
      write_reg(REG_ROWS_USED, ru);
   endtask

   function automatic req_type make_item(logic [1:0] op, longint x, longint y, longint z,
                                         int unsigned s, int unsigned pn,
                                         int unsigned rc, int unsigned rr);
      req_type r;
      r.op = op;
      r.pos_x = x[23:0];
      r.pos_y = y[23:0];
      r.pos_z = z[23:0];
      r.strength = s[15:0];
      r.point_number = pn[19:0];
      r.read_col = rc[9:0];
      r.read_row = rr[6:0];
      return r;
   endfunction

   function automatic longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   // mostly points aimed at a small patch around the principal point, so the
   // depth test sees repeats; the rest reads of hit pixels and full-range noise
   function automatic req_type random_item();
      req_type r;
      longint lo, hi, z, dc, dr;
      int unsigned pick;
      int addr;
      r = REQ_W'({$urandom, $urandom, $urandom, $urandom});
      pick = $urandom_range(99);
      if (pick < 60) begin
         lo = cfg.near_limit < 1 ? 1 : cfg.near_limit;
         hi = cfg.far_limit;
         if (lo <= hi) begin
            if (hi - lo > 4000 && $urandom_range(1)) hi = lo + 4000;
            z = lo + longint'({$urandom, $urandom} % (hi - lo + 1));
         end else begin
            z = $urandom_range(8388607);
         end
         dc = longint'($urandom_range(12)) - 6;
         dr = longint'($urandom_range(8)) - 4;
         r.op = OP_PROJECT;
         r.pos_z = z[23:0];
         r.pos_x = 24'(clamp24(dc * z * 16 / longint'(cfg.focal_col)));
         r.pos_y = 24'(clamp24(dr * z * 16 / longint'(cfg.focal_row)));
      end else if (pick < 85 && hit_addrs.size() > 0) begin
         addr = hit_addrs[$urandom_range(hit_addrs.size() - 1)];
         r.op = $urandom_range(1) ? OP_READ : OP_READ_CLEAR;
         r.read_col = 10'(addr % NUM_COLS);
         r.read_row = 7'(addr / NUM_COLS);
      end else if (pick < 97) begin
         r.op = 2'($urandom_range(2));
      end else begin
         r.op = OP_UNUSED;
      end
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_items.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
   endtask

   task automatic run_phase(int send_pct, int stall_pct, int count);
      wait_drained();
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
      repeat (count) pending_items.push_back(random_item());
      wait_drained();
   endtask

   initial begin
      cfg.near_limit = MIN_RANGE_RST;
      cfg.far_limit = MAX_RANGE_RST;
      cfg.focal_col = FOCAL_RST;
      cfg.focal_row = FOCAL_RST;
      cfg.center_col = CENTER_COL_RST;
      cfg.center_row = CENTER_ROW_RST;
      cfg.cols_used = COLS_USED_RST;
      cfg.rows_used = ROWS_USED_RST;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at reset settings
      pending_items.push_back(make_item(OP_PROJECT, 0, 0, 0, 100, 1, 0, 0));
      pending_items.push_back(make_item(OP_PROJECT, 0, 0, -5, 100, 2, 0, 0));
      pending_items.push_back(make_item(OP_PROJECT, 0, 0, -8388608, 100, 3, 0, 0));
      pending_items.push_back(make_item(OP_PROJECT, 0, 0, 8388607, 100, 4, 0, 0));
      pending_items.push_back(make_item(OP_PROJECT, 0, 0, 100000, 65535, 1048575, 0, 0));
      pending_items.push_back(make_item(OP_READ, 0, 0, 0, 0, 0, 512, 64));
      pending_items.push_back(make_item(OP_PROJECT, 0, 0, 99000, 0, 6, 0, 0));
      pending_items.push_back(make_item(OP_PROJECT, 0, 0, 99500, 50, 7, 0, 0));
      pending_items.push_back(make_item(OP_READ_CLEAR, 0, 0, 0, 0, 0, 512, 64));
      pending_items.push_back(make_item(OP_READ, 0, 0, 0, 0, 0, 512, 64));
      pending_items.push_back(make_item(OP_PROJECT, 0, 0, 1, 1, 8, 0, 0));
      pending_items.push_back(make_item(OP_READ, 0, 0, 0, 0, 0, 512, 64));
      // exact halves round away from zero
      pending_items.push_back(make_item(OP_PROJECT, 1, -1, 1024, 9, 9, 0, 0));
      pending_items.push_back(make_item(OP_PROJECT, -1, 1, 1024, 9, 10, 0, 0));
      pending_items.push_back(make_item(OP_PROJECT, 8388607, 0, 1, 9, 11, 0, 0));
      pending_items.push_back(make_item(OP_PROJECT, -8388608, -8388608, 1, 9, 12, 0, 0));
      pending_items.push_back(make_item(OP_PROJECT, -1, -1, 100, 4, 13, 0, 0));
      pending_items.push_back(make_item(OP_READ, 0, 0, 0, 0, 0, 1023, 127));
      pending_items.push_back(make_item(OP_READ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(OP_UNUSED, -1, -1, -1, 65535, 1048575, 1023, 127));
      wait_drained();

      run_phase(0, 0, 120);
      set_config(0, 8388607, 1048575, 1048575, 1023, 127, 2047, 255);
      run_phase(82, 0, 120);
      set_config(500, 2000, 1, 1, 0, 0, 1, 1);
      run_phase(0, 82, 100);
      set_config(3000, 2000, 4096, 4096, 20, 10, 40, 30);
      run_phase(6, 6, 40);
      set_config(0, 0, 4096, 4096, 20, 10, 40, 30);
      run_phase(0, 0, 30);
      set_config(8388607, 8388607, 16, 16, 5, 3, 0, 0);
      run_phase(0, 0, 30);
      set_config(10, 6000, 2048, 1024, 100, 40, 700, 100);
      // receiver holds off while the sender keeps offering
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = 2000;
      repeat (150) pending_items.push_back(random_item());
      wait_drained();
      run_phase(6, 6, 150);
      set_config(1, 50000, 8192, 8192, 512, 64, 1024, 128);
      run_phase(82, 82, 60);
      run_phase(0, 0, 230);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
